[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sce_pkg.sv]
`default_nettype none

package sce_pkg;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_INTERIOR = 2'd2;

    localparam logic [1:0] SIDE_NONE   = 2'd0;
    localparam logic [1:0] SIDE_AFTER  = 2'd1;
    localparam logic [1:0] SIDE_BEFORE = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_valid;
        logic signed [31:0] slope_value;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0]         point_kind;
        logic [15:0]        point_index;
        logic signed [31:0] point_value;
        logic               is_maximum;
        logic               is_minimum;
        logic [1:0]         undefined_side;
        logic               is_inflection;
        logic               result_last;
    } point_t;

    typedef struct packed {
        logic signed [31:0] prior_value;
        logic               prior_valid;
        logic signed [31:0] prior_slope;
        logic signed [31:0] center_value;
        logic               center_valid;
        logic signed [31:0] center_slope;
    } win_t;

endpackage

`default_nettype wire

[rtl/sce_chan_if.sv]
`default_nettype none

interface sce_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/sce_window.sv]
`default_nettype none

module sce_window #(
    parameter int MAX_SAMPLES = 65536,
    parameter int CW          = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             last,
    input  wire sce_pkg::sample_t sample,
    output sce_pkg::win_t         win,
    output logic [CW-1:0]         count
);
    import sce_pkg::*;
    `include "assert_macros.svh"

    win_t          win_reg, win_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                // end of function: drop the window, next item starts over
                win_next   = '0;
                count_next = '0;
            end
            else
            begin
                win_next.prior_value  = win_reg.center_value;
                win_next.prior_valid  = win_reg.center_valid;
                win_next.prior_slope  = win_reg.center_slope;
                win_next.center_value = sample.sample_value;
                win_next.center_valid = sample.sample_valid;
                win_next.center_slope = sample.slope_value;
                count_next            = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
        end
    end

    assign win   = win_reg;
    assign count = count_reg;

    `SCE_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && last, count_reg == '0 && !win_reg.center_valid, "window not cleared after last item")
    `SCE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= 32'(MAX_SAMPLES - 1), "sample count past limit")

endmodule

`default_nettype wire

[rtl/sce_classify.sv]
`default_nettype none

module sce_classify #(
    parameter int MAX_SAMPLES = 65536,
    parameter int CW          = 16
) (
    input  wire sce_pkg::sample_t sample,
    input  wire sce_pkg::win_t    win,
    input  wire logic [CW-1:0] count,
    input  wire logic        inflection_enable,
    output logic             last,
    output logic [1:0]       num_points,
    output sce_pkg::point_t  point0,
    output sce_pkg::point_t  point1
);
    import sce_pkg::*;

    localparam int XW = (CW > 16) ? CW : 16;

    logic [XW-1:0] idx_ext;
    logic [XW-1:0] idx_prev;
    logic          is_start;
    logic          examine;
    logic          mx, mn, inf;
    logic [1:0]    side;
    logic          interior;
    point_t        p_start, p_int, p_end;
    logic          c_gt_p, c_lt_p, c_gt_x, c_lt_x;
    logic          dc_lt, dc_gt;

    assign idx_ext  = XW'(count);
    assign idx_prev = idx_ext - XW'(1);
    assign is_start = (count == '0);
    assign last     = sample.last_sample || (count == CW'(MAX_SAMPLES - 1));
    assign examine  = (idx_ext >= XW'(2)) && win.center_valid;

    assign c_gt_p = $signed(win.center_value) > $signed(win.prior_value);
    assign c_lt_p = $signed(win.center_value) < $signed(win.prior_value);
    assign c_gt_x = $signed(win.center_value) > $signed(sample.sample_value);
    assign c_lt_x = $signed(win.center_value) < $signed(sample.sample_value);
    assign dc_lt  = $signed(win.center_slope) < $signed(win.prior_slope)
                    && $signed(win.center_slope) < $signed(sample.slope_value);
    assign dc_gt  = $signed(win.center_slope) > $signed(win.prior_slope)
                    && $signed(win.center_slope) > $signed(sample.slope_value);

    always_comb
    begin
        mx   = 1'b0;
        mn   = 1'b0;
        side = SIDE_NONE;
        inf  = 1'b0;
        if (!win.prior_valid && sample.sample_valid)
        begin
            mx   = c_gt_x;
            mn   = c_lt_x;
            side = SIDE_AFTER;
        end
        else if (win.prior_valid && !sample.sample_valid)
        begin
            mx   = c_gt_p;
            mn   = c_lt_p;
            side = SIDE_BEFORE;
        end
        else if (win.prior_valid && sample.sample_valid)
        begin
            mx  = c_gt_p && c_gt_x;
            mn  = c_lt_p && c_lt_x;
            inf = inflection_enable && (dc_lt || dc_gt);
        end
        if (!mx && !mn)
        begin
            side = SIDE_NONE;
        end
    end

    assign interior = examine && (mx || mn || inf);

    always_comb
    begin
        p_start             = '0;
        p_start.point_kind  = KIND_START;
        p_start.point_value = sample.sample_value;

        p_end               = '0;
        p_end.point_kind    = KIND_END;
        p_end.point_index   = idx_ext[15:0];
        p_end.point_value   = sample.sample_value;
        p_end.result_last   = 1'b1;

        p_int                = '0;
        p_int.point_kind     = KIND_INTERIOR;
        p_int.point_index    = idx_prev[15:0];
        p_int.point_value    = win.center_value;
        p_int.is_maximum     = mx;
        p_int.is_minimum     = mn;
        p_int.undefined_side = side;
        p_int.is_inflection  = inf;

        // start and interior never coincide, so at most two points
        num_points = 2'(is_start) + 2'(interior) + 2'(last);
        point1     = p_end;
        if (is_start)
        begin
            point0 = p_start;
        end
        else if (interior)
        begin
            point0 = p_int;
        end
        else
        begin
            point0 = p_end;
        end
        point0.result_last = (num_points == 2'd1);
    end

endmodule

`default_nettype wire

[rtl/sce_out_queue.sv]
`default_nettype none

module sce_out_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  push_n,
    input  wire sce_pkg::point_t push0,
    input  wire sce_pkg::point_t push1,
    output logic             room,
    sce_chan_if.source       point
);
    import sce_pkg::*;
    `include "assert_macros.svh"

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    point_t        q_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_1;

    // accept only with room for a two-point item
    assign room     = cnt_reg <= (PW+1)'(DEPTH - 2);
    assign pop      = point.valid && point.ready;
    assign wr_ptr_1 = wr_ptr_reg + PW'(1);

    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign cnt_next    = cnt_reg + (PW+1)'(push_n) - (PW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[wr_ptr_1] <= push1;
        end
    end

    assign point.valid   = cnt_reg != '0;
    assign point.payload = q_reg[rd_ptr_reg];

    `SCE_ASSERT_NOW(a_no_overflow, clk, rst_n, 1'b1, cnt_reg <= (PW+1)'(DEPTH), "point queue overflow")
    `SCE_ASSERT_NOW(a_push_needs_room, clk, rst_n, push_n != 2'd0, room, "push without room")
    `SCE_ASSERT_NEXT(a_count_track, clk, rst_n, push_n == 2'd2 && !pop, cnt_reg == $past(cnt_reg) + (PW+1)'(2), "count lost a double push")

endmodule

`default_nettype wire

[rtl/sampled_curve_extremum_classifier.sv]
`default_nettype none

// Channel   Dir  Payload                                          Handshake
// sample    in   sample_value, sample_valid, slope_value, last    valid/ready
// point     out  kind, index, value, max, min, side, inflection,  valid/ready
//                result_last
// cfg       in   inflection_enable (1 bit)                        valid/ready
//
// One item is taken per cycle while the queue has room, classified in the
// same cycle against the registered window; points go to a four-entry queue.
// Items with two points (the first sample of a one-sample function, or an
// interior point plus the ending point) take two output beats.
// Input ready drops only while the output queue has fewer than two free slots.
// rst_n clears the window, the sample count, the queue and inflection_enable.
// Output stalls back up through the queue; points are never dropped.

module sampled_curve_extremum_classifier #(
    parameter int MAX_SAMPLES = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sce_chan_if.sink   sample,
    sce_chan_if.source point,
    sce_chan_if.sink   cfg
);
    import sce_pkg::*;

    // sample counter wide enough to reach MAX_SAMPLES-1
    localparam int CW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

    logic          inflection_enable_reg;
    logic          room;
    logic          accept;
    logic          last;
    logic [1:0]    num_points;
    logic [1:0]    push_n;
    point_t        point0, point1;
    win_t          win;
    logic [CW-1:0] count;
    sample_t       sample_item;

    // Config register, always ready: the user writes only while idle (unchecked).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflection_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            inflection_enable_reg <= cfg.payload;
        end
    end

    assign sample_item  = sample.payload;
    assign sample.ready = room;
    assign accept       = sample.valid && room;
    assign push_n       = accept ? num_points : 2'd0;

    // Hold the prior/center samples and the index within the function.
    sce_window #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .last   (last),
        .sample (sample_item),
        .win    (win),
        .count  (count)
    );

    // Classify the center sample and form start/interior/end points.
    sce_classify #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW)
    ) u_classify (
        .sample            (sample_item),
        .win               (win),
        .count             (count),
        .inflection_enable (inflection_enable_reg),
        .last              (last),
        .num_points        (num_points),
        .point0            (point0),
        .point1            (point1)
    );

    // Buffer points so the input side keeps moving under output stalls.
    sce_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (point0),
        .push1  (point1),
        .room   (room),
        .point  (point)
    );

endmodule

`default_nettype wire

[verif/sce_point_checker.sv]
`timescale 1ns / 100ps

module sce_point_checker #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_ready,
    input  sce_pkg::sample_t sample_item,
    input  logic             point_valid,
    input  logic             point_ready,
    input  sce_pkg::point_t  point_item,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               points_outstanding,
    output int               mismatch_count
);
    import sce_pkg::*;

    logic signed [31:0] prior_value;
    logic               prior_valid;
    logic signed [31:0] prior_slope;
    logic signed [31:0] center_value;
    logic               center_valid;
    logic signed [31:0] center_slope;
    int                 next_index;
    logic               inflection_on;
    point_t             expected_points[$];
    int                 errors;

    task automatic clear_window();
        prior_value  = '0;
        prior_valid  = 1'b0;
        prior_slope  = '0;
        center_value = '0;
        center_valid = 1'b0;
        center_slope = '0;
        next_index   = 0;
    endtask

    function automatic point_t terminal_point(input logic [1:0] kind, input logic [15:0] index,
                                              input logic signed [31:0] value);
        point_t p;
        p             = '0;
        p.point_kind  = kind;
        p.point_index = index;
        p.point_value = value;
        return p;
    endfunction

    // Classify one accepted sample against the window and queue its points.
    task automatic classify_sample(input sample_t s);
        point_t     found[2];
        int         n;
        logic       at_end;
        logic       mx;
        logic       mn;
        logic       inf;
        logic [1:0] side;
        n      = 0;
        mx     = 1'b0;
        mn     = 1'b0;
        inf    = 1'b0;
        side   = SIDE_NONE;
        at_end = s.last_sample || (next_index >= MAX_SAMPLES - 1);

        if (next_index == 0)
        begin
            found[n] = terminal_point(KIND_START, 16'd0, s.sample_value);
            n++;
        end

        if (next_index >= 2 && center_valid)
        begin
            if (!prior_valid && s.sample_valid)
            begin
                mx   = center_value > s.sample_value;
                mn   = center_value < s.sample_value;
                side = SIDE_AFTER;
            end
            else if (prior_valid && !s.sample_valid)
            begin
                mx   = center_value > prior_value;
                mn   = center_value < prior_value;
                side = SIDE_BEFORE;
            end
            else if (prior_valid && s.sample_valid)
            begin
                mx = (center_value > prior_value) && (center_value > s.sample_value);
                mn = (center_value < prior_value) && (center_value < s.sample_value);
                if (inflection_on)
                    inf = ((center_slope < prior_slope) && (center_slope < s.slope_value)) ||
                          ((center_slope > prior_slope) && (center_slope > s.slope_value));
            end
            if (mx || mn || inf)
            begin
                found[n]                = '0;
                found[n].point_kind     = KIND_INTERIOR;
                found[n].point_index    = 16'(next_index - 1);
                found[n].point_value    = center_value;
                found[n].is_maximum     = mx;
                found[n].is_minimum     = mn;
                found[n].undefined_side = (mx || mn) ? side : SIDE_NONE;
                found[n].is_inflection  = inf;
                n++;
            end
        end

        if (at_end)
        begin
            found[n] = terminal_point(KIND_END, 16'(next_index), s.sample_value);
            n++;
            clear_window();
        end
        else
        begin
            prior_value  = center_value;
            prior_valid  = center_valid;
            prior_slope  = center_slope;
            center_value = s.sample_value;
            center_valid = s.sample_valid;
            center_slope = s.slope_value;
            next_index   = next_index + 1;
        end

        if (n > 0)
            found[n - 1].result_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_points.push_back(found[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_point(input point_t got);
        point_t want;
        if (expected_points.size() == 0)
        begin
            $display("%0t: unexpected point: expected none, actual %0h", $time, got);
            errors++;
        end
        else
        begin
            want = expected_points.pop_front();
            check_field("point_kind", 32'(want.point_kind), 32'(got.point_kind));
            check_field("point_index", 32'(want.point_index), 32'(got.point_index));
            check_field("point_value", want.point_value, got.point_value);
            check_field("is_maximum", 32'(want.is_maximum), 32'(got.is_maximum));
            check_field("is_minimum", 32'(want.is_minimum), 32'(got.is_minimum));
            check_field("undefined_side", 32'(want.undefined_side), 32'(got.undefined_side));
            check_field("is_inflection", 32'(want.is_inflection), 32'(got.is_inflection));
            check_field("result_last", 32'(want.result_last), 32'(got.result_last));
        end
    endtask

    // Compare before predicting so a point can never match its own item's cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            inflection_on = 1'b0;
            expected_points.delete();
            errors = 0;
            points_outstanding <= 0;
            mismatch_count     <= 0;
        end
        else
        begin
            if (point_valid && point_ready)
                check_point(point_item);
            if (cfg_valid && cfg_ready)
                inflection_on = cfg_data;
            if (sample_valid && sample_ready)
                classify_sample(sample_item);
            points_outstanding <= expected_points.size();
            mismatch_count     <= errors;
        end
    end

endmodule

[verif/tb_sampled_curve_extremum_classifier.sv]
`timescale 1ns / 100ps

module tb_sampled_curve_extremum_classifier;

    import sce_pkg::*;

    localparam int MAX_SAMPLES   = 65536;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;

    localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Pacing knobs, written by the stimulus process only.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_len;
    int hold_seq;

    int cycle_count;
    int points_outstanding;
    int mismatch_count;

    sce_chan_if #(.payload_t(sample_t)) sample_if ();
    sce_chan_if #(.payload_t(point_t))  point_if ();
    sce_chan_if #(.payload_t(logic))    cfg_if ();

    sampled_curve_extremum_classifier #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_if),
        .point (point_if),
        .cfg   (cfg_if)
    );

    sce_point_checker #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) checker_inst (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_if.valid),
        .sample_ready      (sample_if.ready),
        .sample_item       (sample_if.payload),
        .point_valid       (point_if.valid),
        .point_ready       (point_if.ready),
        .point_item        (point_if.payload),
        .cfg_valid         (cfg_if.valid),
        .cfg_ready         (cfg_if.ready),
        .cfg_data          (cfg_if.payload),
        .points_outstanding(points_outstanding),
        .mismatch_count    (mismatch_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a counted stretch on request.
    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left     = 0;
        seen_seq      = 0;
        point_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                point_if.ready <= 1'b0;
            end
            else
                point_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: drop the run if it never drains.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item; hold valid across back-to-back items so it never
    // gets two assignments in one step. Return at the accepting edge.
    task automatic send_sample(input logic signed [31:0] value, input logic valid_bit,
                               input logic signed [31:0] slope, input logic last_bit);
        sample_t item;
        int      gap;
        item.sample_value = value;
        item.sample_valid = valid_bit;
        item.slope_value  = slope;
        item.last_sample  = last_bit;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.payload <= item;
        do
            @(posedge clk);
        while (!sample_if.ready);
    endtask

    // Drop valid, wait for every expected point, then let the window settle
    // since a trailing item may have produced nothing.
    task automatic wait_points_drained();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (points_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_inflection_enable(input logic enable);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= enable;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Value shapes: full range, tiny values that tie often, the extremes,
    // and moderate values of either sign.
    function automatic logic signed [31:0] pick_value(input int shape);
        logic signed [31:0] v;
        case (shape)
            0: v = $urandom;
            1: v = $signed(32'($urandom_range(0, 6))) - 32'sd3;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = MOST_NEGATIVE;
                    1: v = MOST_POSITIVE;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
        endcase
        return v;
    endfunction

    // Mostly whole functions with random content; a few stray items with a
    // random last marker break functions in the middle.
    task automatic run_random(input int n_items);
        int sent;
        int len;
        int value_shape;
        int slope_shape;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_sample($urandom, 1'($urandom_range(0, 1)), $urandom,
                            1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 60);
                value_shape = $urandom_range(0, 3);
                slope_shape = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                begin
                    send_sample(pick_value(value_shape), ($urandom_range(0, 99) < 85),
                                pick_value(slope_shape), (i == len - 1));
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic enable,
                             input int n_items);
        wait_points_drained();
        write_inflection_enable(enable);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_random(n_items);
    endtask

    initial
    begin
        sample_if.valid   = 1'b0;
        sample_if.payload = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_len          = 0;
        hold_seq          = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Run first at the reset setting: inflection off.
        run_random(40);

        wait_points_drained();
        write_inflection_enable(1'b1);

        // One-sample functions: start and end points from one item, the
        // invalid one still reporting its value.
        send_sample(MOST_NEGATIVE, 1'b0, MOST_POSITIVE, 1'b1);
        send_sample(MOST_POSITIVE, 1'b1, MOST_NEGATIVE, 1'b1);
        // Two samples: neither is interior.
        send_sample(32'sd5, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd6, 1'b1, 32'sd0, 1'b1);
        // Alternating extremes: maxima and minima, then a flat tail whose
        // last item gives only the end point.
        send_sample(MOST_NEGATIVE, 1'b1, 32'sd0, 1'b0);
        send_sample(MOST_POSITIVE, 1'b1, 32'sd0, 1'b0);
        send_sample(MOST_NEGATIVE, 1'b1, 32'sd0, 1'b0);
        send_sample(MOST_POSITIVE, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd0, 1'b1);
        // Undefined neighbours on either side, then an invalid last sample.
        send_sample(32'sd1, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd2, 1'b0, 32'sd0, 1'b0);
        send_sample(32'sd9, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd4, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd7, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd3, 1'b0, 32'sd0, 1'b1);
        // Both neighbours undefined: no interior point.
        send_sample(32'sd0, 1'b0, 32'sd0, 1'b0);
        send_sample(32'sd5, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd0, 1'b0, 32'sd0, 1'b1);
        // Flat curve: inflection only where the slope peaks or dips strictly.
        send_sample(32'sd0, 1'b1, 32'sd0, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd5, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1, -32'sd4, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd2, 1'b0);
        send_sample(32'sd0, 1'b1, 32'sd2, 1'b1);

        run_phase(54, 0, 1'b0, 380);
        run_phase(0, 54, 1'b1, 380);
        run_phase(26, 26, 1'b0, 380);
        run_phase(0, 0, 1'b1, 380);

        // Hold off the receiver while items keep coming, so the output
        // queue fills and input ready drops.
        wait_points_drained();
        write_inflection_enable(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = HOLD_CYCLES;
        hold_seq       = hold_seq + 1;
        run_random(60);

        wait_points_drained();
        if (mismatch_count == 0 && points_outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_chan_if.sv
rtl/sce_window.sv
rtl/sce_classify.sv
rtl/sce_out_queue.sv
rtl/sampled_curve_extremum_classifier.sv
verif/sce_point_checker.sv
verif/tb_sampled_curve_extremum_classifier.sv
